FILE: src/fast_walsh_hadamard_transform_assert.svh
// Assertion macros shared by the transform modules.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef FAST_WALSH_HADAMARD_TRANSFORM_ASSERT_SVH
`define FAST_WALSH_HADAMARD_TRANSFORM_ASSERT_SVH

// The condition implies the property in the same cycle.
`define FWHT_ASSERT_IMP(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("fwht: same-cycle check failed");

// The condition implies the property in the following cycle.
`define FWHT_ASSERT_NXT(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("fwht: next-cycle check failed");

`endif

FILE: src/fwht_pkg.sv
`default_nettype none

package fwht_pkg;

    // Coefficient width: 16-bit samples grown by up to six butterfly stages.
    localparam int COEF_W = 22;

    // Width of the length exponent register and its value after reset.
    localparam int CFG_W = 3;
    localparam logic [CFG_W-1:0] LOG_LENGTH_RESET = 3'd6;

    // Register index decoded from paddr[2].
    localparam logic REG_LOG_LENGTH = 1'b0;

    // Commands from the controller to the datapath for one cycle.
    typedef struct packed {
        logic load_we;   // write the accepted sample at index a
        logic bf_rd;     // read the butterfly pair (a, b)
        logic emit_rd;   // read coefficient a for output
        logic last;      // the emitted coefficient is the final one
    } t_cmd;

endpackage

`default_nettype wire

FILE: src/fwht_ctrl.sv
`default_nettype none

module fwht_ctrl #(
    parameter int LOG2_MAX_LENGTH = 6
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [fwht_pkg::CFG_W-1:0]     i_log_length,
    input  wire logic                           i_cfg_wr,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic                           i_issue_ok,
    output fwht_pkg::t_cmd                      o_cmd,
    output logic [LOG2_MAX_LENGTH-1:0]          o_idx_a,
    output logic [LOG2_MAX_LENGTH-1:0]          o_idx_b
);
    import fwht_pkg::*;

    `include "fast_walsh_hadamard_transform_assert.svh"

    localparam int L  = LOG2_MAX_LENGTH;
    localparam int PW = (L > 1) ? L - 1 : 1;
    localparam int SW = (L > 1) ? $clog2(L) : 1;
    localparam logic [CFG_W-1:0] LMAX = CFG_W'(LOG2_MAX_LENGTH);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_BFLY,
        ST_GAP,
        ST_EMIT
    } t_state;

    t_state          r_state, n_state;
    logic [L-1:0]    r_cnt, n_cnt;
    logic [PW-1:0]   r_pair, n_pair;
    logic [SW-1:0]   r_stage, n_stage;

    logic [CFG_W-1:0] eff_log;
    logic [L-1:0]     len_mask;
    logic             cnt_last;
    logic             pair_last;
    logic             stage_last;
    logic [L-1:0]     pair_ext;
    logic [L-1:0]     low_mask;
    logic [L-1:0]     idx_j;
    logic [L-1:0]     idx_k;

    // Clamp the configured exponent to the supported range.
    always_comb begin
        if (i_log_length == '0) begin
            eff_log = CFG_W'(1);
        end else if (i_log_length > LMAX) begin
            eff_log = LMAX;
        end else begin
            eff_log = i_log_length;
        end
    end

    // Vector length minus one, and the end-of-loop flags.
    assign len_mask   = ~({L{1'b1}} << eff_log);
    assign cnt_last   = (r_cnt == len_mask);
    assign pair_last  = (r_pair == PW'(len_mask >> 1));
    assign stage_last = (r_stage == SW'(eff_log - CFG_W'(1)));

    // Butterfly indices: insert a zero at the stage bit of the pair number.
    assign pair_ext = L'(r_pair);
    assign low_mask = ~({L{1'b1}} << r_stage);
    assign idx_j    = ((pair_ext & ~low_mask) << 1) | (pair_ext & low_mask);
    assign idx_k    = idx_j | (L'(1) << r_stage);

    assign o_idx_a = (r_state == ST_BFLY) ? idx_j : r_cnt;
    assign o_idx_b = idx_k;

    // Commands for the datapath.
    assign o_in_ready    = (r_state == ST_LOAD);
    assign o_cmd.load_we = (r_state == ST_LOAD) && i_in_valid;
    assign o_cmd.bf_rd   = (r_state == ST_BFLY) && i_issue_ok;
    assign o_cmd.emit_rd = (r_state == ST_EMIT) && i_issue_ok;
    assign o_cmd.last    = (r_state == ST_EMIT) && i_issue_ok && cnt_last;

    // Sequencing: load, butterfly stages with a gap after each, emit.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_pair  = r_pair;
        n_stage = r_stage;
        unique case (r_state)
            ST_LOAD: begin
                if (i_in_valid) begin
                    if (cnt_last) begin
                        n_cnt   = '0;
                        n_pair  = '0;
                        n_stage = '0;
                        n_state = ST_BFLY;
                    end else begin
                        n_cnt = r_cnt + L'(1);
                    end
                end
            end
            ST_BFLY: begin
                if (i_issue_ok) begin
                    if (pair_last) begin
                        n_pair  = '0;
                        n_state = ST_GAP;
                    end else begin
                        n_pair = r_pair + PW'(1);
                    end
                end
            end
            ST_GAP: begin
                if (stage_last) begin
                    n_cnt   = '0;
                    n_state = ST_EMIT;
                end else begin
                    n_stage = r_stage + SW'(1);
                    n_state = ST_BFLY;
                end
            end
            ST_EMIT: begin
                if (i_issue_ok) begin
                    if (cnt_last) begin
                        n_cnt   = '0;
                        n_state = ST_LOAD;
                    end else begin
                        n_cnt = r_cnt + L'(1);
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
        // A register write discards any partial vector.
        if (i_cfg_wr) begin
            n_state = ST_LOAD;
            n_cnt   = '0;
        end
    end

    // State and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_pair  <= '0;
            r_stage <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pair  <= n_pair;
            r_stage <= n_stage;
        end
    end

    // At most one kind of command in a cycle.
    `FWHT_ASSERT_IMP(a_cmd_excl, 1'b1, $onehot0({o_cmd.load_we, o_cmd.bf_rd, o_cmd.emit_rd}))
    // The last read of a stage is followed by an idle cycle so its write lands first.
    `FWHT_ASSERT_NXT(a_stage_gap, o_cmd.bf_rd && pair_last, !o_cmd.bf_rd && !o_cmd.emit_rd)
    // The final flag only travels with an emit read.
    `FWHT_ASSERT_IMP(a_last_emit, o_cmd.last, o_cmd.emit_rd)

endmodule

`default_nettype wire

FILE: src/fwht_dp.sv
`default_nettype none

module fwht_dp #(
    parameter int LOG2_MAX_LENGTH = 6,
    parameter int SAMPLE_WIDTH    = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire fwht_pkg::t_cmd                         i_cmd,
    input  wire logic [LOG2_MAX_LENGTH-1:0]             i_idx_a,
    input  wire logic [LOG2_MAX_LENGTH-1:0]             i_idx_b,
    input  wire logic signed [SAMPLE_WIDTH-1:0]         i_sample,
    output logic                                        o_issue_ok,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_stall,
    output logic signed [fwht_pkg::COEF_W-1:0]          o_coefficient,
    output logic                                        o_last
);
    import fwht_pkg::*;

    `include "fast_walsh_hadamard_transform_assert.svh"

    localparam int L    = LOG2_MAX_LENGTH;
    localparam int BA_W = (L > 1) ? L - 1 : 1;
    localparam int BD   = 2 ** BA_W;

    // Two banks split by index parity; a butterfly pair always spans both.
    logic signed [COEF_W-1:0] mem0 [BD];
    logic signed [COEF_W-1:0] mem1 [BD];

    logic                     par_a;
    logic [BA_W-1:0]          addr_a;
    logic [BA_W-1:0]          addr_b;
    logic [BA_W-1:0]          raddr0;
    logic [BA_W-1:0]          raddr1;
    logic                     out_adv;
    logic                     s1_free;

    logic                     r_s1_bf;
    logic                     r_s1_emit;
    logic                     r_s1_last;
    logic                     r_s1_sel;
    logic [BA_W-1:0]          r_s1_addr_j;
    logic [BA_W-1:0]          r_s1_addr_k;
    logic signed [COEF_W-1:0] r_rd0;
    logic signed [COEF_W-1:0] r_rd1;

    logic signed [COEF_W-1:0] op_a;
    logic signed [COEF_W-1:0] op_b;
    logic signed [COEF_W-1:0] bf_sum;
    logic signed [COEF_W-1:0] bf_diff;
    logic signed [COEF_W-1:0] load_data;
    logic                     we0;
    logic                     we1;
    logic [BA_W-1:0]          waddr0;
    logic [BA_W-1:0]          waddr1;
    logic signed [COEF_W-1:0] wdata0;
    logic signed [COEF_W-1:0] wdata1;

    logic                     r_out_valid;
    logic signed [COEF_W-1:0] r_out_coef;
    logic                     r_out_last;

    // Bank select and in-bank address of each index.
    assign par_a  = ^i_idx_a;
    assign addr_a = BA_W'(i_idx_a >> 1);
    assign addr_b = BA_W'(i_idx_b >> 1);

    // An emit read waiting in stage one blocks new reads until the output moves.
    assign out_adv    = !r_out_valid || !i_out_stall;
    assign s1_free    = !r_s1_emit || out_adv;
    assign o_issue_ok = s1_free;

    // Read addresses: a butterfly splits the pair across the banks.
    assign raddr0 = (i_cmd.bf_rd && par_a) ? addr_b : addr_a;
    assign raddr1 = (i_cmd.bf_rd && !par_a) ? addr_b : addr_a;

    // Butterfly on the registered read data.
    assign op_a    = r_s1_sel ? r_rd1 : r_rd0;
    assign op_b    = r_s1_sel ? r_rd0 : r_rd1;
    assign bf_sum  = op_a + op_b;
    assign bf_diff = op_a - op_b;

    assign load_data = COEF_W'(i_sample);

    // Write ports: the butterfly result, else an incoming sample.
    always_comb begin
        if (r_s1_bf) begin
            we0    = 1'b1;
            we1    = 1'b1;
            waddr0 = r_s1_sel ? r_s1_addr_k : r_s1_addr_j;
            waddr1 = r_s1_sel ? r_s1_addr_j : r_s1_addr_k;
            wdata0 = r_s1_sel ? bf_diff : bf_sum;
            wdata1 = r_s1_sel ? bf_sum : bf_diff;
        end else begin
            we0    = i_cmd.load_we && !par_a;
            we1    = i_cmd.load_we && par_a;
            waddr0 = addr_a;
            waddr1 = addr_a;
            wdata0 = load_data;
            wdata1 = load_data;
        end
    end

    // Bank memories with registered reads.
    always_ff @(posedge i_clk) begin
        if (we0) begin
            mem0[waddr0] <= wdata0;
        end
        if (s1_free) begin
            r_rd0 <= mem0[raddr0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we1) begin
            mem1[waddr1] <= wdata1;
        end
        if (s1_free) begin
            r_rd1 <= mem1[raddr1];
        end
    end

    // Stage one control, alongside the read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_bf   <= 1'b0;
            r_s1_emit <= 1'b0;
        end else if (s1_free) begin
            r_s1_bf   <= i_cmd.bf_rd;
            r_s1_emit <= i_cmd.emit_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free) begin
            r_s1_last   <= i_cmd.last;
            r_s1_sel    <= par_a;
            r_s1_addr_j <= addr_a;
            r_s1_addr_k <= addr_b;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv) begin
            r_out_coef <= r_s1_sel ? r_rd1 : r_rd0;
            r_out_last <= r_s1_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_coefficient = r_out_coef;
    assign o_last        = r_out_last;

    // A stalled emit keeps its read data until the output register takes it.
    `FWHT_ASSERT_NXT(a_s1_hold, r_s1_emit && r_out_valid && i_out_stall,
                     r_s1_emit && $stable(r_rd0) && $stable(r_rd1))
    // Stage one never holds a butterfly and an emit together.
    `FWHT_ASSERT_IMP(a_s1_excl, 1'b1, !(r_s1_bf && r_s1_emit))

endmodule

`default_nettype wire

FILE: src/fast_walsh_hadamard_transform.sv
// A vector's N samples load first, then log2(N) butterfly stages run, each with a gap
// state after it, on the single butterfly unit over two parity-split memory banks.
// Coefficients pass the stage-one read register and the output register, one per cycle
// unless i_out_stall holds them; input stalls until the last coefficient read issues.
// Reset (i_rst_n low, synchronous) empties the pipeline, clears the sample count and
// sets log_length to 6; the work buffer holds no defined value until loaded.
`default_nettype none

module fast_walsh_hadamard_transform #(
    parameter int LOG2_MAX_LENGTH = 6,
    parameter int SAMPLE_WIDTH    = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Configuration port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [2:0]                         paddr,
    input  wire logic [31:0]                        pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready,
    // Sample input
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0]     i_sample,
    // Coefficient output
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic signed [fwht_pkg::COEF_W-1:0]      o_coefficient,
    output logic                                    o_last
);
    import fwht_pkg::*;

    logic [CFG_W-1:0]             r_log_length;
    logic                         cfg_wr;
    logic                         in_ready;
    logic                         issue_ok;
    t_cmd                         cmd;
    logic [LOG2_MAX_LENGTH-1:0]   idx_a;
    logic [LOG2_MAX_LENGTH-1:0]   idx_b;

    // Register write and readback; the port never waits.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_LOG_LENGTH);

    always_comb begin
        if (paddr[2] == REG_LOG_LENGTH) begin
            prdata = {{(32 - CFG_W){1'b0}}, r_log_length};
        end else begin
            prdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log_length <= LOG_LENGTH_RESET;
        end else if (cfg_wr) begin
            r_log_length <= pwdata[CFG_W-1:0];
        end
    end

    assign o_in_stall = !in_ready;

    // Sequencer.
    fwht_ctrl #(
        .LOG2_MAX_LENGTH (LOG2_MAX_LENGTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_log_length (r_log_length),
        .i_cfg_wr     (cfg_wr),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (in_ready),
        .i_issue_ok   (issue_ok),
        .o_cmd        (cmd),
        .o_idx_a      (idx_a),
        .o_idx_b      (idx_b)
    );

    // Memory banks, butterfly and output register.
    fwht_dp #(
        .LOG2_MAX_LENGTH (LOG2_MAX_LENGTH),
        .SAMPLE_WIDTH    (SAMPLE_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_idx_a       (idx_a),
        .i_idx_b       (idx_b),
        .i_sample      (i_sample),
        .o_issue_ok    (issue_ok),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_coefficient (o_coefficient),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire

FILE: tb/fast_walsh_hadamard_transform_tb.sv
`timescale 1ns / 1ps

module fast_walsh_hadamard_transform_tb;

    import fwht_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int MAX_LOG       = 6;
    localparam int SAMPLE_W      = 16;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES  = 400;
    localparam int TIMEOUT_CYCLES = 200_000;
    localparam int PRINT_CAP     = 50;

    // Byte addresses of the register file; only the length exponent exists.
    localparam logic [2:0] ADDR_LOG   = {REG_LOG_LENGTH, 2'b00};
    localparam logic [2:0] ADDR_SPARE = {~REG_LOG_LENGTH, 2'b00};

    typedef enum logic [1:0] {ROW_WRITE, ROW_READ, ROW_SAMPLE} t_row_kind;

    // One line of the directed script. For a sample that completes a two-point
    // vector, typed marks that the two coefficients are given in the row.
    typedef struct packed {
        t_row_kind                 kind;
        logic [2:0]                addr;
        logic [31:0]               data;
        logic                      typed;
        logic signed [COEF_W-1:0]  c0;
        logic signed [COEF_W-1:0]  c1;
    } t_script_row;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef;
        logic                     last;
    } t_coef_rec;

    localparam int N_ROWS = 28;
    localparam t_script_row SCRIPT [N_ROWS] = '{
        '{ROW_READ,   ADDR_LOG,   32'sd6,      1'b0, 22'sd0,      22'sd0},
        '{ROW_WRITE,  ADDR_LOG,   32'sd1,      1'b0, 22'sd0,      22'sd0},
        '{ROW_READ,   ADDR_LOG,   32'sd1,      1'b0, 22'sd0,      22'sd0},
        '{ROW_SAMPLE, ADDR_LOG,   32'sd32767,  1'b0, 22'sd0,      22'sd0},
        '{ROW_SAMPLE, ADDR_LOG,   -32'sd32768, 1'b1, -22'sd1,     22'sd65535},
        '{ROW_SAMPLE, ADDR_LOG,   -32'sd32768, 1'b0, 22'sd0,      22'sd0},
        '{ROW_SAMPLE, ADDR_LOG,   -32'sd32768, 1'b1, -22'sd65536, 22'sd0},
        '{ROW_SAMPLE, ADDR_LOG,   32'sd32767,  1'b0, 22'sd0,      22'sd0},
        '{ROW_SAMPLE, ADDR_LOG,   32'sd32767,  1'b1, 22'sd65534,  22'sd0},
        '{ROW_SAMPLE, ADDR_LOG,   32'sd0,      1'b0, 22'sd0,      22'sd0},
        '{ROW_SAMPLE, ADDR_LOG,   32'sd0,      1'b1, 22'sd0,      22'sd0},
        // A write to an unmapped address must keep the half-loaded vector.
        '{ROW_SAMPLE, ADDR_LOG,   32'sd123,    1'b0, 22'sd0,      22'sd0},
        '{ROW_WRITE,  ADDR_SPARE, 32'sd3,      1'b0, 22'sd0,      22'sd0},
        '{ROW_SAMPLE, ADDR_LOG,   32'sd77,     1'b1, 22'sd200,    22'sd46},
        // A length write mid-vector drops the loaded sample; zero acts as one.
        '{ROW_SAMPLE, ADDR_LOG,   -32'sd5,     1'b0, 22'sd0,      22'sd0},
        '{ROW_WRITE,  ADDR_LOG,   32'sd0,      1'b0, 22'sd0,      22'sd0},
        '{ROW_READ,   ADDR_LOG,   32'sd0,      1'b0, 22'sd0,      22'sd0},
        '{ROW_SAMPLE, ADDR_LOG,   32'sd1,      1'b0, 22'sd0,      22'sd0},
        '{ROW_SAMPLE, ADDR_LOG,   32'sd2,      1'b1, 22'sd3,      -22'sd1},
        '{ROW_WRITE,  ADDR_LOG,   32'sd2,      1'b0, 22'sd0,      22'sd0},
        '{ROW_SAMPLE, ADDR_LOG,   32'sd32767,  1'b0, 22'sd0,      22'sd0},
        '{ROW_SAMPLE, ADDR_LOG,   -32'sd32768, 1'b0, 22'sd0,      22'sd0},
        '{ROW_SAMPLE, ADDR_LOG,   32'sd32767,  1'b0, 22'sd0,      22'sd0},
        '{ROW_SAMPLE, ADDR_LOG,   -32'sd32768, 1'b0, 22'sd0,      22'sd0},
        // Exponents above the maximum saturate; leave a partial vector behind.
        '{ROW_WRITE,  ADDR_LOG,   32'sd7,      1'b0, 22'sd0,      22'sd0},
        '{ROW_READ,   ADDR_LOG,   32'sd7,      1'b0, 22'sd0,      22'sd0},
        '{ROW_SAMPLE, ADDR_LOG,   -32'sd1,     1'b0, 22'sd0,      22'sd0},
        '{ROW_SAMPLE, ADDR_LOG,   32'sd3,      1'b0, 22'sd0,      22'sd0}
    };

    // Length exponents visited by the random part, extremes included.
    localparam int N_PHASES = 6;
    localparam logic [2:0] PHASE_LOGS [N_PHASES] = '{3'd7, 3'd2, 3'd0, 3'd3, 3'd1, 3'd4};

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [2:0]                  paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;
    logic                        i_in_valid;
    logic                        o_in_stall;
    logic signed [SAMPLE_W-1:0]  i_sample;
    logic                        o_out_valid;
    logic                        i_out_stall;
    logic signed [COEF_W-1:0]    o_coefficient;
    logic                        o_last;

    // Shadow state of the transform.
    logic [2:0]                  shadow_log;
    logic signed [COEF_W-1:0]    work_mem [64];
    logic signed [COEF_W-1:0]    new_coefs [64];
    int                          fill_count;

    t_coef_rec                   expected_coefs [$];
    int                          mismatches;
    int                          in_quiet;
    int                          out_quiet;
    int                          out_hold;

    fast_walsh_hadamard_transform #(
        .LOG2_MAX_LENGTH (MAX_LOG),
        .SAMPLE_WIDTH    (SAMPLE_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_sample      (i_sample),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_coefficient (o_coefficient),
        .o_last        (o_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
    endtask

    // Wait draw for one transaction; now and then a quiet stretch with no waits.
    function automatic int pick_wait(inout int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            quiet = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    function automatic int active_log(input logic [2:0] raw);
        if (raw < 3'd1) return 1;
        if (raw > MAX_LOG) return MAX_LOG;
        return int'(raw);
    endfunction

    // Loads one sample; on the closing sample of a vector runs the butterfly
    // stages in place and returns the number of coefficients in new_coefs.
    function automatic int fwht_accept(input logic signed [SAMPLE_W-1:0] s);
        int len;
        int span;
        int j;
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        len = 1 << active_log(shadow_log);
        if (fill_count >= len) fill_count = 0;
        work_mem[fill_count] = COEF_W'(s);
        fill_count++;
        if (fill_count < len) return 0;
        for (span = 1; span < len; span = span << 1) begin
            for (j = 0; j < len; j++) begin
                if ((j & span) == 0) begin
                    a = work_mem[j];
                    b = work_mem[j | span];
                    work_mem[j] = a + b;
                    work_mem[j | span] = a - b;
                end
            end
        end
        fill_count = 0;
        for (j = 0; j < len; j++) new_coefs[j] = work_mem[j];
        return len;
    endfunction

    // Drives one sample transaction after a random gap and records what it yields.
    task automatic accept_sample(input logic signed [SAMPLE_W-1:0] s, input logic typed,
                                 input logic signed [COEF_W-1:0] c0,
                                 input logic signed [COEF_W-1:0] c1);
        int gap;
        int cnt;
        int k;
        t_coef_rec rec;
        gap = pick_wait(in_quiet);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= s;
        do @(posedge i_clk); while (o_in_stall);
        cnt = fwht_accept(s);
        for (k = 0; k < cnt; k++) begin
            rec.coef = new_coefs[k];
            if (typed) rec.coef = (k == 0) ? c0 : c1;
            rec.last = (k == cnt - 1);
            expected_coefs.push_back(rec);
        end
    endtask

    // Hold off the sender until every coefficient is out, then let the block go quiet.
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (expected_coefs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr[2] == REG_LOG_LENGTH) begin
            shadow_log = data[2:0];
            fill_count = 0;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic cfg_read_check(input logic [2:0] addr, input logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            flag_mismatch($sformatf("register read at %0d: got %0h, want %0h",
                                    addr, prdata, want));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Output side: compare every coefficient transaction, then stall for a random spell.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            out_hold = 0;
            out_quiet = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_coefs.size() == 0) begin
                    flag_mismatch($sformatf("coefficient %0d with nothing pending",
                                            o_coefficient));
                end else begin
                    if (o_coefficient !== expected_coefs[0].coef) begin
                        flag_mismatch($sformatf("coefficient: got %0d, want %0d",
                                                o_coefficient, expected_coefs[0].coef));
                    end
                    if (o_last !== expected_coefs[0].last) begin
                        flag_mismatch($sformatf("last flag: got %0b, want %0b",
                                                o_last, expected_coefs[0].last));
                    end
                    void'(expected_coefs.pop_front());
                end
                out_hold = pick_wait(out_quiet);
            end
            if (out_hold > 0) begin
                i_out_stall <= 1'b1;
                out_hold--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        int r;
        int ph;
        int v;
        int k;
        int len;
        int nvec;
        int style;
        int part;
        logic [31:0] wdata;
        logic signed [SAMPLE_W-1:0] s;

        i_rst_n     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        i_in_valid  = 1'b0;
        i_sample    = '0;
        shadow_log  = LOG_LENGTH_RESET;
        fill_count  = 0;
        mismatches  = 0;
        in_quiet    = 0;
        foreach (work_mem[i]) work_mem[i] = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed script: register accesses only with the block idle.
        for (r = 0; r < N_ROWS; r++) begin
            case (SCRIPT[r].kind)
                ROW_WRITE: begin
                    settle_block();
                    cfg_write(SCRIPT[r].addr, SCRIPT[r].data);
                end
                ROW_READ: begin
                    settle_block();
                    cfg_read_check(SCRIPT[r].addr, SCRIPT[r].data);
                end
                default: begin
                    accept_sample(SCRIPT[r].data[SAMPLE_W-1:0], SCRIPT[r].typed,
                                  SCRIPT[r].c0, SCRIPT[r].c1);
                end
            endcase
        end

        // Random part: whole vectors per length setting, of random content or of full-scale
        // extremes, with an occasional cut-off vector that the next write throws away.
        for (ph = 0; ph < N_PHASES; ph++) begin
            settle_block();
            wdata = $urandom();
            wdata[2:0] = PHASE_LOGS[ph];
            cfg_write(ADDR_LOG, wdata);
            cfg_read_check(ADDR_LOG, {29'd0, PHASE_LOGS[ph]});
            len  = 1 << active_log(PHASE_LOGS[ph]);
            nvec = (len >= 16) ? 1 : $urandom_range(1, 2);
            for (v = 0; v < nvec; v++) begin
                // Sometimes let the whole vector drain before the next one starts.
                if ($urandom_range(0, 4) == 0) begin
                    i_in_valid <= 1'b0;
                    do @(posedge i_clk); while (expected_coefs.size() != 0);
                end
                style = $urandom_range(0, 5);
                for (k = 0; k < len; k++) begin
                    case (style)
                        0:       s = 16'sh8000;
                        1:       s = 16'sh7fff;
                        2:       s = k[0] ? 16'sh8000 : 16'sh7fff;
                        default: s = SAMPLE_W'($urandom());
                    endcase
                    accept_sample(s, 1'b0, '0, '0);
                end
            end
            if ($urandom_range(0, 1) == 1) begin
                part = $urandom_range(1, (len - 1 < 8) ? len - 1 : 8);
                for (k = 0; k < part; k++) begin
                    s = SAMPLE_W'($urandom());
                    accept_sample(s, 1'b0, '0, '0);
                end
            end
        end

        i_in_valid <= 1'b0;
        while (expected_coefs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/fwht_pkg.sv
src/fwht_ctrl.sv
src/fwht_dp.sv
src/fast_walsh_hadamard_transform.sv
tb/fast_walsh_hadamard_transform_tb.sv
